/* rtl/etk_pkg.sv */
// ----------------------------------------------------------------------------
// etk_pkg
// Shared types and constants of the expression tokenizer: token kinds,
// character codes, the token record and the front-to-back queue types.
// ----------------------------------------------------------------------------
package etk_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int POS_BITS_DEF   = 16;

	// Fixed widths of the result fields.
	localparam int KIND_W  = 4;
	localparam int VAL_W   = 32;
	localparam int OFS_W   = 16;
	localparam int LEN_W   = 16;
	localparam int CHAR_W  = 8;

	// Front-to-back queue.
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QLVL_W  = $clog2(QDEPTH + 1);

	typedef enum logic [KIND_W-1:0] {
		K_NUMBER = 4'd0,
		K_IDENT  = 4'd1,
		K_STRING = 4'd2,
		K_PLUS   = 4'd3,
		K_MINUS  = 4'd4,
		K_MULT   = 4'd5,
		K_DIV    = 4'd6,
		K_OPEN   = 4'd7,
		K_CLOSE  = 4'd8,
		K_ERROR  = 4'd9,
		K_END    = 4'd10
	} kind_t;

	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
	localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;

	typedef struct packed {
		kind_t              kind;
		logic [VAL_W-1:0]   number_value;
		logic [OFS_W-1:0]   start_offset;
		logic [LEN_W-1:0]   text_length;
		logic [CHAR_W-1:0]  bad_char;
	} tok_t;

	// One queue entry holds all tokens caused by one character.
	typedef struct packed {
		logic two;
		tok_t t0;
		tok_t t1;
	} qentry_t;

	typedef struct packed {
		logic    valid;
		qentry_t entry;
	} push_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QLVL_W-1:0] level;
	} qstat_t;

	function automatic tok_t mk_tok(input kind_t k, input logic [VAL_W-1:0] v,
			input logic [OFS_W-1:0] s, input logic [LEN_W-1:0] l,
			input logic [CHAR_W-1:0] b);
		tok_t t;
		t.kind         = k;
		t.number_value = v;
		t.start_offset = s;
		t.text_length  = l;
		t.bad_char     = b;
		return t;
	endfunction

endpackage

/* rtl/etk_if.sv */
// ----------------------------------------------------------------------------
// etk_if
// Handshake channels of the tokenizer: characters in, tokens out.
// ----------------------------------------------------------------------------
interface etk_char_if import etk_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              end_mark;

	modport source (output valid, output char_code, output end_mark, input ready);
	modport sink   (input valid, input char_code, input end_mark, output ready);
endinterface

interface etk_tok_if import etk_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [VAL_W-1:0]  number_value;
	logic [OFS_W-1:0]  start_offset;
	logic [LEN_W-1:0]  text_length;
	logic [CHAR_W-1:0] bad_char;
	logic              last;

	modport source (output valid, output kind, output number_value, output start_offset,
		output text_length, output bad_char, output last, input ready);
	modport sink   (input valid, input kind, input number_value, input start_offset,
		input text_length, input bad_char, input last, output ready);
endinterface

/* rtl/etk_front.sv */
// ----------------------------------------------------------------------------
// etk_front
// Scanner: takes one character per cycle while the queue has room, runs the
// lexer state machine, pushes the zero, one or two resulting tokens to the queue.
// ----------------------------------------------------------------------------
module etk_front import etk_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int POS_BITS   = POS_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	etk_char_if.sink       chars,
	input  qstat_t         qstat,
	output push_t          push
);

	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_SLASH   = 3'd1,
		M_COMMENT = 3'd2,
		M_NUMBER  = 3'd3,
		M_IDENT   = 3'd4,
		M_STRING  = 3'd5
	} mode_t;

	mode_t                 mode_q, mode_d;
	logic [VALUE_BITS-1:0] accum_q, accum_d;
	logic [POS_BITS-1:0]   pos_q, pos_d;
	logic [POS_BITS-1:0]   start_q, start_d;
	logic [POS_BITS-1:0]   len_q, len_d;
	logic                  halted_q, halted_d;

	logic                  accept;
	logic [CHAR_W-1:0]     c;
	logic                  is_dig, is_let, is_spc;
	logic [3:0]            dig;
	logic [VALUE_BITS+3:0] mul10;
	logic [POS_BITS-1:0]   len_inc;
	logic [VALUE_BITS+31:0] acc_ext;
	logic [POS_BITS+15:0]  start_ext, len_ext;
	logic [VAL_W-1:0]      acc_o;
	logic [OFS_W-1:0]      start_o;
	logic [LEN_W-1:0]      len_o;
	logic                  fv, sv, done;
	tok_t                  ft, st;

	assign chars.ready = !qstat.full;
	assign accept      = chars.valid && chars.ready;
	assign c           = chars.char_code;

	assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_let = ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
	assign is_spc = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	assign dig    = 4'(c - CH_ZERO);

	// accum * 10 + digit; any bit above the value width means saturation.
	assign mul10 = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1)
		+ {{VALUE_BITS{1'b0}}, dig};
	assign len_inc = (&len_q) ? len_q : len_q + 1'b1;

	assign acc_ext   = {32'b0, accum_q};
	assign start_ext = {16'b0, start_q};
	assign len_ext   = {16'b0, len_q};
	assign acc_o     = acc_ext[VAL_W-1:0];
	assign start_o   = start_ext[OFS_W-1:0];
	assign len_o     = len_ext[LEN_W-1:0];

	always_comb begin
		mode_d   = mode_q;
		accum_d  = accum_q;
		pos_d    = pos_q + 1'b1;
		start_d  = start_q;
		len_d    = len_q;
		halted_d = halted_q;
		fv       = 1'b0;
		sv       = 1'b0;
		done     = 1'b0;
		ft       = mk_tok(K_NUMBER, '0, '0, '0, '0);
		st       = mk_tok(K_NUMBER, '0, '0, '0, '0);

		if (chars.end_mark) begin
			if (!halted_q) begin
				unique case (mode_q)
					M_SLASH: begin
						fv = 1'b1;
						ft = mk_tok(K_DIV, '0, '0, '0, '0);
					end
					M_NUMBER: begin
						fv = 1'b1;
						ft = mk_tok(K_NUMBER, acc_o, '0, '0, '0);
					end
					M_IDENT: begin
						fv = 1'b1;
						ft = mk_tok(K_IDENT, '0, start_o, len_o, '0);
					end
					M_STRING: begin
						fv = 1'b1;
						ft = mk_tok(K_STRING, '0, start_o, len_o, '0);
					end
					default: ;
				endcase
			end
			sv       = 1'b1;
			st       = mk_tok(K_END, '0, '0, '0, '0);
			mode_d   = M_IDLE;
			accum_d  = '0;
			pos_d    = '0;
			start_d  = '0;
			len_d    = '0;
			halted_d = 1'b0;
		end else if (!halted_q) begin
			// First finish or extend the open token.
			unique case (mode_q)
				M_SLASH: begin
					if (c == CH_SLASH) begin
						mode_d = M_COMMENT;
						done   = 1'b1;
					end else begin
						fv     = 1'b1;
						ft     = mk_tok(K_DIV, '0, '0, '0, '0);
						mode_d = M_IDLE;
					end
				end
				M_COMMENT: begin
					if (c == CH_NL) begin
						mode_d = M_IDLE;
					end
					done = 1'b1;
				end
				M_NUMBER: begin
					if (is_dig) begin
						accum_d = (|mul10[VALUE_BITS+3:VALUE_BITS]) ? '1
							: mul10[VALUE_BITS-1:0];
						done = 1'b1;
					end else begin
						fv     = 1'b1;
						ft     = mk_tok(K_NUMBER, acc_o, '0, '0, '0);
						mode_d = M_IDLE;
					end
				end
				M_IDENT: begin
					if (is_dig || is_let) begin
						len_d = len_inc;
						done  = 1'b1;
					end else begin
						fv     = 1'b1;
						ft     = mk_tok(K_IDENT, '0, start_o, len_o, '0);
						mode_d = M_IDLE;
					end
				end
				M_STRING: begin
					if (c == CH_QUOTE) begin
						fv     = 1'b1;
						ft     = mk_tok(K_STRING, '0, start_o, len_o, '0);
						mode_d = M_IDLE;
					end else begin
						len_d = len_inc;
					end
					done = 1'b1;
				end
				default: mode_d = M_IDLE;
			endcase

			// Then treat the character as the start of something new.
			if (!done) begin
				priority if (is_spc) begin
				end else if (c == CH_SLASH) begin
					mode_d = M_SLASH;
				end else if (is_dig) begin
					mode_d  = M_NUMBER;
					accum_d = {{(VALUE_BITS-4){1'b0}}, dig};
				end else if (is_let) begin
					mode_d  = M_IDENT;
					start_d = pos_q;
					len_d   = {{(POS_BITS-1){1'b0}}, 1'b1};
				end else if (c == CH_QUOTE) begin
					mode_d  = M_STRING;
					start_d = pos_q + 1'b1;
					len_d   = '0;
				end else if (c == CH_OPEN) begin
					sv = 1'b1;
					st = mk_tok(K_OPEN, '0, '0, '0, '0);
				end else if (c == CH_CLOSE) begin
					sv = 1'b1;
					st = mk_tok(K_CLOSE, '0, '0, '0, '0);
				end else if (c == CH_PLUS) begin
					sv = 1'b1;
					st = mk_tok(K_PLUS, '0, '0, '0, '0);
				end else if (c == CH_MINUS) begin
					sv = 1'b1;
					st = mk_tok(K_MINUS, '0, '0, '0, '0);
				end else if (c == CH_STAR) begin
					sv = 1'b1;
					st = mk_tok(K_MULT, '0, '0, '0, '0);
				end else begin
					sv       = 1'b1;
					st       = mk_tok(K_ERROR, '0, '0, '0, c);
					halted_d = 1'b1;
					mode_d   = M_IDLE;
				end
			end
		end
	end

	always_comb begin
		push.valid    = accept && (fv || sv);
		push.entry.two = fv && sv;
		push.entry.t0 = fv ? ft : st;
		push.entry.t1 = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			accum_q  <= '0;
			pos_q    <= '0;
			start_q  <= '0;
			len_q    <= '0;
			halted_q <= 1'b0;
		end else if (accept) begin
			mode_q   <= mode_d;
			accum_q  <= accum_d;
			pos_q    <= pos_d;
			start_q  <= start_d;
			len_q    <= len_d;
			halted_q <= halted_d;
		end
	end

endmodule

/* rtl/etk_queue.sv */
// ----------------------------------------------------------------------------
// etk_queue
// Small FIFO between scanner and output stage; one entry per character
// that produced tokens.
// ----------------------------------------------------------------------------
module etk_queue import etk_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  logic    pop,
	output qentry_t head,
	output qstat_t  qstat
);

	qentry_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QLVL_W-1:0] level_q;
	logic              do_push, do_pop;

	assign qstat.level = level_q;
	assign qstat.full  = (level_q == QLVL_W'(QDEPTH));
	assign qstat.empty = (level_q == '0);
	assign head        = mem_q[rd_ptr_q];

	assign do_push = push.valid && !qstat.full;
	assign do_pop  = pop && !qstat.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

/* rtl/etk_back.sv */
// ----------------------------------------------------------------------------
// etk_back
// Output stage: takes queue entries apart into single tokens and holds
// each in the output register until the sink takes it.
// ----------------------------------------------------------------------------
module etk_back import etk_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  qentry_t  head,
	input  qstat_t   qstat,
	output logic     pop,
	etk_tok_if.source tokens
);

	logic valid_q;
	logic sub_q;
	logic last_q;
	tok_t tok_q;
	logic load;
	logic take;
	logic final_one;

	assign load      = !valid_q || tokens.ready;
	assign take      = load && !qstat.empty;
	// The second slot, or the first of a one-token entry, ends the entry.
	assign final_one = sub_q || !head.two;
	assign pop       = take && final_one;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
			last_q  <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
			last_q  <= final_one;
			sub_q   <= !final_one;
		end else if (load) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tok_q <= sub_q ? head.t1 : head.t0;
		end
	end

	assign tokens.valid        = valid_q;
	assign tokens.kind         = tok_q.kind;
	assign tokens.number_value = tok_q.number_value;
	assign tokens.start_offset = tok_q.start_offset;
	assign tokens.text_length  = tok_q.text_length;
	assign tokens.bad_char     = tok_q.bad_char;
	assign tokens.last         = last_q;

endmodule

/* rtl/expression_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// expression_tokenizer_unit
// Streaming tokenizer for arithmetic text: characters in, tokens out.
// ----------------------------------------------------------------------------
// With the output register free, a token passes from its accepted character into
// the queue and then from the queue head into the output register. One character
// per cycle is taken while the queue has room; the single output register moves
// one token per cycle while the sink is ready, so a two-token character uses it
// twice. The four-entry queue absorbs short bursts of those; once it is full the
// input waits. Reset clears scanner state, queue pointers and output valid at once.
module expression_tokenizer_unit import etk_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int POS_BITS   = POS_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	etk_char_if.sink  chars,
	etk_tok_if.source tokens
);

	push_t   push;
	qstat_t  qstat;
	qentry_t head;
	logic    pop;

	etk_front #(
		.VALUE_BITS (VALUE_BITS),
		.POS_BITS   (POS_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.qstat  (qstat),
		.push   (push)
	);

	etk_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	etk_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.tokens (tokens)
	);

	// The scanner never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !qstat.full)
		else $error("push into full queue");

	// An end token closes the transaction group of its character.
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && (tokens.kind == K_END) |-> tokens.last)
		else $error("end token without last");

	// Only error tokens carry a character.
	a_bad_char: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && (tokens.kind != K_ERROR) |-> (tokens.bad_char == '0))
		else $error("bad_char set on non-error token");

	// A popped entry leaves the queue one lower unless a push refills it.
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !qstat.empty && !push.valid |=> qstat.level == $past(qstat.level) - 1'b1)
		else $error("queue level mismatch after pop");

endmodule

/* bench/tb_expression_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// tb_expression_tokenizer_unit
// Self-checking bench for the streaming expression tokenizer. Characters are
// driven through the input channel, and every accepted transaction updates a
// cycle-free tokenizer predictor inside a scoreboard class. Tokens from the
// output channel are compared field by field, in order, with the predicted
// ones. The stimulus is mostly well-formed expressions with random content,
// plus error characters, unterminated strings, comments and random bytes.
// Both channels stall at random, and one long receiver hold-off fills the
// block up.
// ----------------------------------------------------------------------------
module tb_expression_tokenizer_unit import etk_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 4000;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_SLASH,
		SCAN_COMMENT,
		SCAN_NUMBER,
		SCAN_IDENT,
		SCAN_STRING
	} scan_mode_t;

	typedef struct packed {
		tok_t tok;
		logic last;
	} token_entry_t;

	class token_scoreboard;
		scan_mode_t        mode;
		logic [VAL_W-1:0]  accum;
		logic [OFS_W-1:0]  position;
		logic [OFS_W-1:0]  tstart;
		logic [LEN_W-1:0]  tlen;
		bit                halted;
		token_entry_t      expected_tokens[$];
		int                mismatches;
		int                checked;

		function new();
			clear_state();
			mismatches = 0;
			checked    = 0;
		endfunction

		function void clear_state();
			mode     = SCAN_IDLE;
			accum    = '0;
			position = '0;
			tstart   = '0;
			tlen     = '0;
			halted   = 1'b0;
		endfunction

		static function bit is_digit(input logic [CHAR_W-1:0] c);
			return c >= CH_ZERO && c <= CH_NINE;
		endfunction

		static function bit is_letter(input logic [CHAR_W-1:0] c);
			return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
		endfunction

		static function bit is_space(input logic [CHAR_W-1:0] c);
			return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		endfunction

		function tok_t make_token(input kind_t k, input logic [VAL_W-1:0] v,
				input logic [OFS_W-1:0] s, input logic [LEN_W-1:0] l,
				input logic [CHAR_W-1:0] b);
			tok_t t;
			t.kind         = k;
			t.number_value = v;
			t.start_offset = s;
			t.text_length  = l;
			t.bad_char     = b;
			return t;
		endfunction

		// Advances the tokenizer by one accepted character and queues the tokens
		// that it causes.
		function void note_char(input logic [CHAR_W-1:0] c, input logic e);
			tok_t                found[$];
			token_entry_t        entry;
			bit                  consumed;
			logic [VAL_W+3:0]    grown;
			consumed = 1'b0;
			if (e) begin
				if (!halted) begin
					case (mode)
						SCAN_SLASH:  found.push_back(make_token(K_DIV, '0, '0, '0, '0));
						SCAN_NUMBER: found.push_back(make_token(K_NUMBER, accum, '0, '0, '0));
						SCAN_IDENT:  found.push_back(make_token(K_IDENT, '0, tstart, tlen, '0));
						SCAN_STRING: found.push_back(make_token(K_STRING, '0, tstart, tlen, '0));
						default: ;
					endcase
				end
				found.push_back(make_token(K_END, '0, '0, '0, '0));
				clear_state();
			end else if (halted) begin
				position++;
			end else begin
				case (mode)
					SCAN_SLASH: begin
						if (c == CH_SLASH) begin
							mode     = SCAN_COMMENT;
							consumed = 1'b1;
						end else begin
							found.push_back(make_token(K_DIV, '0, '0, '0, '0));
							mode = SCAN_IDLE;
						end
					end
					SCAN_COMMENT: begin
						if (c == CH_NL)
							mode = SCAN_IDLE;
						consumed = 1'b1;
					end
					SCAN_NUMBER: begin
						if (is_digit(c)) begin
							grown = {4'b0, accum} * (VAL_W+4)'(10)
								+ (VAL_W+4)'(c - CH_ZERO);
							if (grown > {4'b0, {VAL_W{1'b1}}})
								accum = '1;
							else
								accum = grown[VAL_W-1:0];
							consumed = 1'b1;
						end else begin
							found.push_back(make_token(K_NUMBER, accum, '0, '0, '0));
							mode = SCAN_IDLE;
						end
					end
					SCAN_IDENT: begin
						if (is_digit(c) || is_letter(c)) begin
							if (tlen != '1)
								tlen++;
							consumed = 1'b1;
						end else begin
							found.push_back(make_token(K_IDENT, '0, tstart, tlen, '0));
							mode = SCAN_IDLE;
						end
					end
					SCAN_STRING: begin
						if (c == CH_QUOTE) begin
							found.push_back(make_token(K_STRING, '0, tstart, tlen, '0));
							mode = SCAN_IDLE;
						end else if (tlen != '1) begin
							tlen++;
						end
						consumed = 1'b1;
					end
					default: mode = SCAN_IDLE;
				endcase

				// A character that closed a token is scanned again from idle.
				if (!consumed && !is_space(c)) begin
					if (c == CH_SLASH) begin
						mode = SCAN_SLASH;
					end else if (is_digit(c)) begin
						mode  = SCAN_NUMBER;
						accum = VAL_W'(c - CH_ZERO);
					end else if (is_letter(c)) begin
						mode   = SCAN_IDENT;
						tstart = position;
						tlen   = LEN_W'(1);
					end else if (c == CH_QUOTE) begin
						mode   = SCAN_STRING;
						tstart = position + 1'b1;
						tlen   = '0;
					end else if (c == CH_OPEN) begin
						found.push_back(make_token(K_OPEN, '0, '0, '0, '0));
					end else if (c == CH_CLOSE) begin
						found.push_back(make_token(K_CLOSE, '0, '0, '0, '0));
					end else if (c == CH_PLUS) begin
						found.push_back(make_token(K_PLUS, '0, '0, '0, '0));
					end else if (c == CH_MINUS) begin
						found.push_back(make_token(K_MINUS, '0, '0, '0, '0));
					end else if (c == CH_STAR) begin
						found.push_back(make_token(K_MULT, '0, '0, '0, '0));
					end else begin
						found.push_back(make_token(K_ERROR, '0, '0, '0, c));
						halted = 1'b1;
						mode   = SCAN_IDLE;
					end
				end
				position++;
			end

			foreach (found[i]) begin
				entry.tok  = found[i];
				entry.last = (i == found.size() - 1);
				expected_tokens.push_back(entry);
			end
		endfunction

		function int pending();
			return expected_tokens.size();
		endfunction

		task report_mismatch(input string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task compare_field(input string name, input logic [VAL_W-1:0] got,
				input logic [VAL_W-1:0] want);
			if (got !== want)
				report_mismatch($sformatf("token %0d %s got %0d expected %0d",
					checked, name, got, want));
		endtask

		task check_token(input tok_t got, input logic got_last);
			token_entry_t want;
			if (expected_tokens.size() == 0) begin
				report_mismatch($sformatf("token of kind %0d with none expected", got.kind));
			end else begin
				want = expected_tokens.pop_front();
				compare_field("kind", got.kind, want.tok.kind);
				compare_field("number_value", got.number_value, want.tok.number_value);
				compare_field("start_offset", got.start_offset, want.tok.start_offset);
				compare_field("text_length", got.text_length, want.tok.text_length);
				compare_field("bad_char", got.bad_char, want.tok.bad_char);
				compare_field("last", got_last, want.last);
			end
			checked++;
		endtask
	endclass

	logic clk;
	logic arst_n;

	etk_char_if char_bus();
	etk_tok_if  token_bus();

	expression_tokenizer_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (char_bus),
		.tokens (token_bus)
	);

	token_scoreboard board = new();
	int src_idle_pct;
	int sink_idle_pct;
	int hold_left;
	int chars_sent;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [CHAR_W-1:0] rand_letter();
		return CHAR_W'($urandom_range(0, 1) ? $urandom_range(CH_UC_A, CH_UC_Z)
			: $urandom_range(CH_LC_A, CH_LC_Z));
	endfunction

	function automatic logic [CHAR_W-1:0] rand_digit();
		return CHAR_W'($urandom_range(CH_ZERO, CH_NINE));
	endfunction

	function automatic logic [CHAR_W-1:0] rand_space();
		int r;
		r = $urandom_range(0, 5);
		return (r == 0) ? CH_SPACE : CH_TAB + CHAR_W'(r - 1);
	endfunction

	function automatic logic [CHAR_W-1:0] rand_byte_except(input logic [CHAR_W-1:0] banned);
		logic [CHAR_W-1:0] r;
		do
			r = CHAR_W'($urandom_range(0, 255));
		while (r == banned);
		return r;
	endfunction

	task automatic send_char(input logic [CHAR_W-1:0] c, input logic e);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			char_bus.valid = 1'b0;
			@(negedge clk);
		end
		char_bus.valid     = 1'b1;
		char_bus.char_code = c;
		char_bus.end_mark  = e;
		@(posedge clk);
		while (!char_bus.ready)
			@(posedge clk);
		board.note_char(c, e);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	task automatic send_end();
		send_char(CHAR_W'($urandom_range(0, 255)), 1'b1);
	endtask

	// One expression of random pieces, usually closed by the end marker.
	task automatic send_expression();
		int pieces;
		int pick;
		int n;
		logic [CHAR_W-1:0] b;
		logic [CHAR_W-1:0] ops[6];
		ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_OPEN, CH_CLOSE};
		pieces = $urandom_range(1, 10);
		for (int p = 0; p < pieces; p++) begin
			pick = $urandom_range(0, 99);
			if (pick < 22) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
				repeat (n) send_char(rand_digit(), 1'b0);
			end else if (pick < 42) begin
				send_char(rand_letter(), 1'b0);
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
				repeat (n) send_char($urandom_range(0, 1) ? rand_letter() : rand_digit(), 1'b0);
			end else if (pick < 52) begin
				send_char(CH_QUOTE, 1'b0);
				repeat ($urandom_range(0, 8)) send_char(rand_byte_except(CH_QUOTE), 1'b0);
				send_char(CH_QUOTE, 1'b0);
			end else if (pick < 80) begin
				send_char(ops[$urandom_range(0, 5)], 1'b0);
			end else if (pick < 88) begin
				send_char(CH_SLASH, 1'b0);
				send_char(CH_SLASH, 1'b0);
				repeat ($urandom_range(0, 8)) send_char(rand_byte_except(CH_NL), 1'b0);
				send_char(CH_NL, 1'b0);
			end else if (pick < 97) begin
				repeat ($urandom_range(1, 3)) send_char(rand_space(), 1'b0);
			end else begin
				send_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
			end
			if ($urandom_range(0, 1))
				send_char(rand_space(), 1'b0);
		end

		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			// Error character, then a few characters that the halted block drops.
			do
				b = CHAR_W'($urandom_range(0, 255));
			while (token_scoreboard::is_space(b) || token_scoreboard::is_digit(b)
				|| token_scoreboard::is_letter(b) || b == CH_QUOTE || b == CH_SLASH
				|| b == CH_OPEN || b == CH_CLOSE || b == CH_PLUS || b == CH_MINUS
				|| b == CH_STAR);
			send_char(b, 1'b0);
			repeat ($urandom_range(0, 4)) send_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
			send_end();
		end else if (pick < 14) begin
			send_char(CH_QUOTE, 1'b0);
			repeat ($urandom_range(0, 5)) send_char(rand_byte_except(CH_QUOTE), 1'b0);
			send_end();
		end else if (pick >= 20) begin
			send_end();
		end
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		token_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				token_bus.ready = 1'b0;
				hold_left--;
			end else begin
				token_bus.ready = ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : token_monitor
		tok_t got;
		if (arst_n && token_bus.valid && token_bus.ready) begin
			got.kind         = kind_t'(token_bus.kind);
			got.number_value = token_bus.number_value;
			got.start_offset = token_bus.start_offset;
			got.text_length  = token_bus.text_length;
			got.bad_char     = token_bus.bad_char;
			board.check_token(got, token_bus.last);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (char_bus.valid && char_bus.ready)
				|| (token_bus.valid && token_bus.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		char_bus.valid     = 1'b0;
		char_bus.char_code = '0;
		char_bus.end_mark  = 1'b0;
		arst_n             = 1'b0;
		hold_left          = 0;
		chars_sent         = 0;
		src_idle_pct       = 7;
		sink_idle_pct      = 49;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every operator, a two-token step, a saturating number, an unterminated
		// string, and an error with a character dropped while halted.
		send_text("Az9+ -(*)/4294967296");
		send_end();
		send_text("\"q");
		send_end();
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_end();

		while (chars_sent < 420)
			send_expression();
		send_end();

		src_idle_pct  = 49;
		sink_idle_pct = 7;
		while (chars_sent < 840)
			send_expression();
		send_end();

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		hold_left     = 400;
		while (chars_sent < 1230)
			send_expression();
		send_end();

		@(negedge clk);
		char_bus.valid = 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
